FILE: hw/rtl/swled_pkg.sv
package swled_pkg;

    // frame geometry
    localparam int FRAME_BITS      = 46;
    localparam int BITS_W          = $clog2(FRAME_BITS + 1);
    localparam int PREAMBLE_CYCLES = 2;
    localparam int CHAN_W          = 12;
    localparam int CMD_W           = FRAME_BITS - 3 * CHAN_W;
    localparam logic [CMD_W-1:0] CMD_WORD = CMD_W'(10'h3AA);

    // timer and configuration port
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [CFG_DATA_W-1:0] EDGE_TICKS_RST   = 16'd2;
    localparam logic [CFG_DATA_W-1:0] STAGE1_TICKS_RST = 16'd8;
    localparam logic [CFG_DATA_W-1:0] STAGE3_TICKS_RST = 16'd8;
    localparam logic [CFG_DATA_W-1:0] EOS_TICKS_RST    = 16'd200;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE3 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EOS    = 2'd3;

    // operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CHAN = 2'd1;
    localparam logic [1:0] OP_RAW  = 2'd2;

    // frame phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PRE  = 2'd1,
        PH_BITS = 2'd2,
        PH_EOS  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [CHAN_W-1:0]     chan_a;
        logic [CHAN_W-1:0]     chan_b;
        logic [CHAN_W-1:0]     chan_c;
        logic [FRAME_BITS-1:0] raw_frame;
    } in_word_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
    } out_word_t;

endpackage

FILE: hw/rtl/swled_core.sv
module swled_core #(
    parameter int TIMER_WIDTH = swled_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  swled_pkg::in_word_t                   in_word,
    input  logic                                  cfg_we,
    input  logic [swled_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [swled_pkg::CFG_DATA_W-1:0]      cfg_data,
    output swled_pkg::out_word_t                  result
);
    import swled_pkg::*;

    // configuration registers
    logic [TIMER_WIDTH-1:0] edge_reg, stage1_reg, stage3_reg, eos_reg;

    // frame state
    phase_t                 phase_reg, phase_next;
    logic [1:0]             idx_reg, idx_next;
    logic [1:0]             pre_reg, pre_next;
    logic [BITS_W-1:0]      bits_reg, bits_next;
    logic [FRAME_BITS-1:0]  shift_reg, shift_next;
    logic [TIMER_WIDTH-1:0] count_reg, count_next;

    // skip logic inputs and outputs
    phase_t                 st_phase, sk_phase;
    logic [2:0]             st_start;
    logic [1:0]             st_pre, sk_pre;
    logic [BITS_W-1:0]      st_bits, sk_bits;
    logic [FRAME_BITS-1:0]  st_shift, sk_shift;
    logic [1:0]             sk_idx;

    logic [3:0]             nz;
    logic                   any_nz, eos_nz, found;
    logic [1:0]             fidx, first_any;
    logic [TIMER_WIDTH-1:0] cur_len, cnt_inc;
    logic                   is_tick, is_start, seg_done;
    logic [FRAME_BITS-1:0]  load_frame;

    function automatic logic seg_level(phase_t ph, logic [1:0] idx, logic msb);
        logic lvl;
        lvl = 1'b0;
        if (ph == PH_PRE || ph == PH_BITS) begin
            if (idx == 2'd0)
                lvl = 1'b1;
            else if (idx == 2'd2 && ph == PH_BITS)
                lvl = msb;
        end
        return lvl;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg   <= TIMER_WIDTH'(EDGE_TICKS_RST);
            stage1_reg <= TIMER_WIDTH'(STAGE1_TICKS_RST);
            stage3_reg <= TIMER_WIDTH'(STAGE3_TICKS_RST);
            eos_reg    <= TIMER_WIDTH'(EOS_TICKS_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EDGE:   edge_reg   <= TIMER_WIDTH'(cfg_data);
                REG_STAGE1: stage1_reg <= TIMER_WIDTH'(cfg_data);
                REG_STAGE3: stage3_reg <= TIMER_WIDTH'(cfg_data);
                REG_EOS:    eos_reg    <= TIMER_WIDTH'(cfg_data);
                default:    ;
            endcase
        end
    end

    // nonzero segment flags
    assign nz[0]  = (edge_reg != '0);
    assign nz[1]  = (stage1_reg != '0);
    assign nz[2]  = (edge_reg != '0);
    assign nz[3]  = (stage3_reg != '0);
    assign any_nz = |nz;
    assign eos_nz = (eos_reg != '0);

    // current segment length
    always_comb
    begin
        if (phase_reg == PH_EOS)
            cur_len = eos_reg;
        else
        begin
            case (idx_reg)
                2'd0:    cur_len = edge_reg;
                2'd1:    cur_len = stage1_reg;
                2'd2:    cur_len = edge_reg;
                default: cur_len = stage3_reg;
            endcase
        end
    end

    assign is_tick  = (in_word.op == OP_TICK);
    assign is_start = (phase_reg == PH_IDLE) && (in_word.op == OP_CHAN || in_word.op == OP_RAW);
    assign cnt_inc  = count_reg + TIMER_WIDTH'(1);
    assign seg_done = (cnt_inc >= cur_len);
    assign load_frame = (in_word.op == OP_CHAN)
                      ? {CMD_WORD, in_word.chan_a, in_word.chan_b, in_word.chan_c}
                      : in_word.raw_frame;

    // skip source: a new frame or the segment after the current one
    always_comb
    begin
        if (is_start)
        begin
            st_phase = PH_PRE;
            st_start = 3'd0;
            st_pre   = 2'(PREAMBLE_CYCLES);
            st_bits  = '0;
            st_shift = load_frame;
        end
        else
        begin
            st_phase = phase_reg;
            st_start = {1'b0, idx_reg} + 3'd1;
            st_pre   = pre_reg;
            st_bits  = bits_reg;
            st_shift = shift_reg;
        end
    end

    // first nonzero segment at or after the start index, and in a full cycle
    always_comb
    begin
        found     = 1'b0;
        fidx      = 2'd0;
        first_any = 2'd0;
        for (int j = 3; j >= 0; j--)
        begin
            if (3'(j) >= st_start && nz[j])
            begin
                found = 1'b1;
                fidx  = 2'(j);
            end
            if (nz[j])
                first_any = 2'(j);
        end
    end

    // skip empty segments; a cycle with no nonzero segment empties the frame
    always_comb
    begin
        sk_phase = st_phase;
        sk_idx   = fidx;
        sk_pre   = st_pre;
        sk_bits  = st_bits;
        sk_shift = st_shift;
        if (!found)
        begin
            sk_idx = 2'd0;
            if (st_phase == PH_PRE)
            begin
                sk_pre = st_pre - 2'd1;
                if (sk_pre == 2'd0)
                begin
                    sk_phase = PH_BITS;
                    sk_bits  = BITS_W'(FRAME_BITS);
                end
            end
            else
            begin
                sk_shift = {st_shift[FRAME_BITS-2:0], 1'b0};
                sk_bits  = st_bits - BITS_W'(1);
                if (sk_bits == '0)
                    sk_phase = PH_EOS;
            end
            if (sk_phase == PH_EOS)
            begin
                if (!eos_nz)
                    sk_phase = PH_IDLE;
            end
            else if (any_nz)
                sk_idx = first_any;
            else
                sk_phase = eos_nz ? PH_EOS : PH_IDLE;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        pre_next   = pre_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        if (push)
        begin
            if (is_tick)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (!seg_done)
                        count_next = cnt_inc;
                    else
                    begin
                        count_next = '0;
                        if (phase_reg == PH_EOS)
                            phase_next = PH_IDLE;
                        else
                        begin
                            phase_next = sk_phase;
                            idx_next   = sk_idx;
                            pre_next   = sk_pre;
                            bits_next  = sk_bits;
                            shift_next = sk_shift;
                        end
                    end
                end
            end
            else if (is_start)
            begin
                count_next = '0;
                phase_next = sk_phase;
                idx_next   = sk_idx;
                pre_next   = sk_pre;
                bits_next  = sk_bits;
                shift_next = sk_shift;
            end
        end
    end

    // result word
    always_comb
    begin
        if (is_tick)
        begin
            result.line_level = seg_level(phase_reg, idx_reg, shift_reg[FRAME_BITS-1]);
            result.busy_res   = (phase_reg != PH_IDLE);
            result.accepted   = 1'b0;
        end
        else
        begin
            result.line_level = seg_level(phase_next, idx_next, shift_next[FRAME_BITS-1]);
            result.busy_res   = (phase_next != PH_IDLE);
            result.accepted   = is_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            pre_reg   <= '0;
            bits_reg  <= '0;
            shift_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            pre_reg   <= pre_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

    // data bits phase always has bits pending
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BITS |-> (bits_reg != '0 && bits_reg <= BITS_W'(FRAME_BITS)))
        else $error("bit count out of range in data phase");

    // preamble count is one or two and no data bits are counted yet
    a_pre_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PRE |-> ((pre_reg == 2'd1 || pre_reg == 2'd2) && bits_reg == '0))
        else $error("preamble state inconsistent");

    // a tick while idle leaves the block idle
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (push && in_word.op == OP_TICK && phase_reg == PH_IDLE) |=> phase_reg == PH_IDLE)
        else $error("idle tick started a frame");

endmodule

FILE: hw/rtl/swled_obuf.sv
module swled_obuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  swled_pkg::out_word_t  push_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output swled_pkg::out_word_t  out_word
);
    import swled_pkg::*;

    out_word_t head_reg, skid_reg;
    logic      head_valid_reg, skid_valid_reg;
    logic      pop;

    assign pop        = head_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = head_valid_reg;
    assign out_word   = head_reg;

    // two-entry output buffer, head drives the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (!head_valid_reg || pop)
            begin
                head_reg       <= push_word;
                head_valid_reg <= 1'b1;
            end
            else
            begin
                skid_reg       <= push_word;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
            head_valid_reg <= 1'b0;
    end

    // skid entry only exists behind a head entry
    a_skid_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid word without head word");

    // a stalled skid word is kept
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid word lost under stall");

    // draining the last word empties the buffer
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && out_ready && !skid_valid_reg && !push_valid) |=> !head_valid_reg)
        else $error("buffer did not drain");

endmodule

FILE: hw/rtl/single_wire_led_frame_transmitter_top.sv
// output: each accepted input word's result is registered in the output buffer
// throughput: one input word per cycle; the
//   two-entry output buffer takes one more word during a stall, then in_ready
//   drops until the spare entry drains
// reset: rst_n asynchronous active low; frame goes idle, line low, timing
//   registers return to edge 2, stage1 8, stage3 8, eos 200 ticks
module single_wire_led_frame_transmitter_top #(
    parameter int TIMER_WIDTH = swled_pkg::TIMER_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  swled_pkg::in_word_t               in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output swled_pkg::out_word_t              out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swled_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swled_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import swled_pkg::*;

    out_word_t result;
    logic      in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;

    // frame sequencer and timing registers
    swled_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    // result buffer
    swled_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_accept),
        .push_ready (in_ready),
        .push_word  (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

endmodule
